// File: rtl/core/trailing_average_filter_assert.svh
// Assertion macros for the trailing average filter; they compile away under synthesis.
`ifndef TRAILING_AVERAGE_FILTER_ASSERT_SVH
`define TRAILING_AVERAGE_FILTER_ASSERT_SVH
`ifndef SYNTHESIS
`define TAF_ASSERT_IMPLY(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);
`define TAF_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);
`else
`define TAF_ASSERT_IMPLY(lbl, ck, rn, ante, cons, msg)
`define TAF_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)
`endif
`endif

// File: rtl/core/taf_pkg.sv
// Package with the beat types and function codes of the trailing average filter.
`default_nettype none
package taf_pkg;

	localparam int SAMPLE_W = 12;
	localparam int AVG_W    = 12;
	localparam int COUNT_W  = 6;

	localparam logic FUNC_APPEND = 1'b0;
	localparam logic FUNC_CLEAR  = 1'b1;

	typedef struct packed {
		logic                func;
		logic [SAMPLE_W-1:0] sample;
	} taf_in_t;

	typedef struct packed {
		logic [AVG_W-1:0]   average;
		logic [COUNT_W-1:0] valid_count;
		logic               window_full;
		logic               empty_res;
	} taf_out_t;

endpackage
`default_nettype wire

// File: rtl/core/trailing_average_filter.sv
// Top level of the trailing average filter: ring memory, running sum and serial divider.
// The filter keeps the last WINDOW samples in a single-port ring memory and a running
// sum of the entries that count. Each request beat yields exactly one result beat with
// the floor of the mean, the number of entries in it, the full flag and the empty flag.
// An append passes through the states SUM, DIV and OUT before its result is loaded;
// in DIV the restoring divider produces one quotient bit per cycle of the SUM_W-bit
// quotient, where SUM_W is the sample width plus the bits of WINDOW. A clear passes
// through SUM and OUT only. One request is processed at a time, and a new request is
// taken while the previous result still waits in the output register.
`default_nettype none
`include "trailing_average_filter_assert.svh"

module trailing_average_filter
	import taf_pkg::*;
#(
	parameter int WINDOW      = 50,
	parameter int SAMPLE_BITS = 12
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_stall,
	input  wire taf_in_t  req,
	output logic          res_valid,
	input  wire logic     res_stall,
	output taf_out_t      res
);

	localparam int SB_EFF = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
	localparam int POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W  = $clog2(WINDOW + 1);
	localparam int SUM_W  = SB_EFF + CNT_W;
	localparam int ITER_W = $clog2(SUM_W + 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SUM  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	state_t              state_q;
	logic [SB_EFF-1:0]   ring_q [WINDOW];
	logic [SB_EFF-1:0]   rd_q;
	logic                func_q;
	logic [SB_EFF-1:0]   sample_q;
	logic [POS_W-1:0]    pos_q;
	logic                full_q;
	logic [SUM_W-1:0]    sum_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W:0]      rem_q;
	logic [SUM_W-1:0]    quo_q;
	logic [ITER_W-1:0]   iter_q;
	logic                res_valid_q;
	taf_out_t            res_q;

	logic                accept;
	logic [SB_EFF-1:0]   req_sample;
	logic                last_pos;
	logic [POS_W-1:0]    pos_next;
	logic                full_next;
	logic [SUM_W-1:0]    sum_next;
	logic [CNT_W-1:0]    count_next;
	logic [CNT_W:0]      trial;
	logic                res_free;

	assign req_stall  = (state_q != ST_IDLE);
	assign accept     = req_valid && !req_stall;
	assign req_sample = req.sample[SB_EFF-1:0];
	assign res_valid  = res_valid_q;
	assign res        = res_q;
	assign res_free   = !res_valid_q || !res_stall;

	// The read returns the entry that the write of the same cycle replaces.
	always_ff @(posedge clk) begin
		if (accept && req.func == FUNC_APPEND) begin
			rd_q          <= ring_q[pos_q];
			ring_q[pos_q] <= req_sample;
		end
	end

	always_comb begin
		last_pos   = (pos_q == POS_W'(WINDOW - 1));
		pos_next   = last_pos ? '0 : pos_q + 1'b1;
		full_next  = full_q || last_pos;
		sum_next   = sum_q + SUM_W'(sample_q) - (full_q ? SUM_W'(rd_q) : '0);
		count_next = full_next ? CNT_W'(WINDOW) : CNT_W'(pos_next);
		trial      = {rem_q[CNT_W-1:0], quo_q[SUM_W-1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			full_q      <= 1'b0;
			sum_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && res_free) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					if (func_q == FUNC_CLEAR) begin
						pos_q   <= '0;
						full_q  <= 1'b0;
						sum_q   <= '0;
						state_q <= ST_OUT;
					end else begin
						pos_q   <= pos_next;
						full_q  <= full_next;
						sum_q   <= sum_next;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (iter_q == ITER_W'(1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (res_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q   <= req.func;
			sample_q <= req_sample;
		end
		if (state_q == ST_SUM) begin
			rem_q  <= '0;
			iter_q <= ITER_W'(SUM_W);
			if (func_q == FUNC_CLEAR) begin
				count_q <= '0;
				quo_q   <= '0;
			end else begin
				count_q <= count_next;
				quo_q   <= sum_next;
			end
		end else if (state_q == ST_DIV) begin
			iter_q <= iter_q - 1'b1;
			if (trial >= {1'b0, count_q}) begin
				rem_q <= trial - {1'b0, count_q};
				quo_q <= {quo_q[SUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[SUM_W-2:0], 1'b0};
			end
		end
		if (state_q == ST_OUT && res_free) begin
			res_q.average     <= AVG_W'(quo_q);
			res_q.valid_count <= COUNT_W'(count_q);
			res_q.window_full <= full_q;
			res_q.empty_res   <= (count_q == '0);
		end
	end

	`TAF_ASSERT_IMPLY(a_empty_zero, clk, arst_n, res_valid && res.empty_res, res.average == '0 && res.valid_count == '0, "empty result with nonzero average or count")
	`TAF_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, accept, req_stall && !(state_q == ST_IDLE), "request taken but no processing started")
	`TAF_ASSERT_IMPLY(a_pos_range, clk, arst_n, 1'b1, pos_q <= POS_W'(WINDOW - 1), "write position beyond the window")

endmodule
`default_nettype wire
